@@ design/jsu_pkg.sv @@
// Shared types and constants for the JSON string unescaper.
// No dependencies; imported by every module of the block.
package jsu_pkg;

	typedef enum logic [2:0] {
		MODE_IDLE   = 3'd0,
		MODE_TEXT   = 3'd1,
		MODE_ESCAPE = 3'd2,
		MODE_HEX    = 3'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_BYTE      = 2'd0,
		ST_DONE      = 2'd1,
		ST_MALFORMED = 2'd2,
		ST_TOO_LONG  = 2'd3
	} status_t;

	localparam logic [15:0] LIMIT_RESET = 16'd32768;

	// Most results that one input byte can cause.
	localparam int MAX_RES  = 3;
	localparam int FIFO_AW  = 2;
	localparam int FIFO_DEPTH = 1 << FIFO_AW;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_QMARK = 8'h3f;

	typedef struct packed {
		logic [7:0] data;
		status_t    status;
		logic       last;
	} result_t;

	typedef struct packed {
		mode_t                     mode;
		logic [15:0]               cp;
		logic [1:0]                hex_cnt;
		logic [15:0]               count;
		logic [1:0]                nres;
		result_t [MAX_RES-1:0]     res;
	} decode_t;

endpackage

@@ design/jsu_decode.sv @@
// Next-state and result logic for one raw byte of a JSON string.
// Depends on jsu_pkg.
module jsu_decode (
	input  logic [7:0]       in_byte,
	input  logic             start_req,
	input  jsu_pkg::mode_t   mode,
	input  logic [15:0]      cp,
	input  logic [1:0]       hex_cnt,
	input  logic [15:0]      count,
	input  logic [15:0]      limit,
	output jsu_pkg::decode_t dec
);
	import jsu_pkg::*;

	logic        hex_ok;
	logic [3:0]  hex_v;
	logic [15:0] cp_new;
	logic        app;
	logic [1:0]  app_n;
	logic [7:0]  app_b [MAX_RES];
	logic [16:0] sum;

	// hex digit value, either case
	always_comb begin
		hex_ok = 1'b1;
		hex_v  = 4'd0;
		if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
			hex_v = 4'(in_byte - 8'h30);
		end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
			hex_v = 4'(in_byte - 8'h57);
		end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
			hex_v = 4'(in_byte - 8'h37);
		end else begin
			hex_ok = 1'b0;
		end
	end

	assign cp_new = {cp[11:0], hex_v};

	always_comb begin
		dec         = '0;
		dec.mode    = mode;
		dec.cp      = cp;
		dec.hex_cnt = hex_cnt;
		dec.count   = count;
		app         = 1'b0;
		app_n       = 2'd0;
		for (int i = 0; i < MAX_RES; i++) begin
			app_b[i] = 8'h00;
		end

		if (start_req) begin
			dec.count   = '0;
			dec.cp      = '0;
			dec.hex_cnt = '0;
			if (in_byte == CH_QUOTE) begin
				dec.mode = MODE_TEXT;
			end else begin
				dec.mode   = MODE_IDLE;
				dec.nres   = 2'd1;
				dec.res[0] = '{data: 8'h00, status: ST_MALFORMED, last: 1'b1};
			end
		end else begin
			unique case (mode)
				MODE_TEXT: begin
					if (in_byte == CH_QUOTE) begin
						dec.mode   = MODE_IDLE;
						dec.nres   = 2'd1;
						dec.res[0] = '{data: 8'h00, status: ST_DONE, last: 1'b1};
					end else if (in_byte < 8'h20) begin
						dec.mode   = MODE_IDLE;
						dec.nres   = 2'd1;
						dec.res[0] = '{data: 8'h00, status: ST_MALFORMED, last: 1'b1};
					end else if (in_byte == CH_BSLASH) begin
						dec.mode = MODE_ESCAPE;
					end else begin
						app      = 1'b1;
						app_n    = 2'd1;
						app_b[0] = in_byte;
					end
				end
				MODE_ESCAPE: begin
					dec.mode = MODE_TEXT;
					app      = 1'b1;
					app_n    = 2'd1;
					case (in_byte) inside
						CH_QUOTE, CH_BSLASH, CH_SLASH: app_b[0] = in_byte;
						8'h62: app_b[0] = 8'h08;
						8'h66: app_b[0] = 8'h0c;
						8'h6e: app_b[0] = 8'h0a;
						8'h72: app_b[0] = 8'h0d;
						8'h74: app_b[0] = 8'h09;
						8'h75: begin
							app         = 1'b0;
							app_n       = 2'd0;
							dec.cp      = '0;
							dec.hex_cnt = '0;
							dec.mode    = MODE_HEX;
						end
						default: begin
							app        = 1'b0;
							app_n      = 2'd0;
							dec.mode   = MODE_IDLE;
							dec.nres   = 2'd1;
							dec.res[0] = '{data: 8'h00, status: ST_MALFORMED, last: 1'b1};
						end
					endcase
				end
				MODE_HEX: begin
					if (!hex_ok) begin
						dec.mode   = MODE_IDLE;
						dec.nres   = 2'd1;
						dec.res[0] = '{data: 8'h00, status: ST_MALFORMED, last: 1'b1};
					end else begin
						dec.cp = cp_new;
						if (hex_cnt != 2'd3) begin
							dec.hex_cnt = hex_cnt + 2'd1;
						end else begin
							dec.hex_cnt = 2'd0;
							dec.mode    = MODE_TEXT;
							app         = 1'b1;
							// UTF-8 encode; surrogates map to '?'
							if (cp_new[15:7] == '0) begin
								app_n    = 2'd1;
								app_b[0] = cp_new[7:0];
							end else if (cp_new[15:11] == '0) begin
								app_n    = 2'd2;
								app_b[0] = {3'b110, cp_new[10:6]};
								app_b[1] = {2'b10, cp_new[5:0]};
							end else if (cp_new[15:11] == 5'b11011) begin
								app_n    = 2'd1;
								app_b[0] = CH_QMARK;
							end else begin
								app_n    = 2'd3;
								app_b[0] = {4'b1110, cp_new[15:12]};
								app_b[1] = {2'b10, cp_new[11:6]};
								app_b[2] = {2'b10, cp_new[5:0]};
							end
						end
					end
				end
				default: begin
					dec.mode = MODE_IDLE;
				end
			endcase

			// count after the append, one bit wider to catch the limit
			sum = {1'b0, count} + {15'd0, app_n};

			if (app) begin
				if (sum > {1'b0, limit}) begin
					dec.mode   = MODE_IDLE;
					dec.nres   = 2'd1;
					dec.res[0] = '{data: 8'h00, status: ST_TOO_LONG, last: 1'b1};
				end else begin
					dec.count = sum[15:0];
					dec.nres  = app_n;
					for (int i = 0; i < MAX_RES; i++) begin
						dec.res[i] = '{data: app_b[i], status: ST_BYTE,
							last: (2'(i + 1) == app_n)};
					end
				end
			end
		end
		if (start_req) begin
			sum = '0;
		end
	end

endmodule

@@ design/jsu_out_fifo.sv @@
// Result queue: takes up to three results per cycle, gives one per cycle while out_stall is low.
// Depends on jsu_pkg.
module jsu_out_fifo (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [1:0]                          push_n,
	input  jsu_pkg::result_t [jsu_pkg::MAX_RES-1:0] push_data,
	output logic                                room,
	output logic                                out_valid,
	input  logic                                out_stall,
	output jsu_pkg::result_t                    head
);
	import jsu_pkg::*;

	result_t                mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0]     wr_ptr_q;
	logic [FIFO_AW-1:0]     rd_ptr_q;
	logic [FIFO_AW:0]       count_q;
	logic                   pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && !out_stall;
	// room for a full burst, counted before this cycle's pop
	assign room      = (count_q <= (FIFO_AW+1)'(FIFO_DEPTH - MAX_RES));
	assign head      = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++) begin
			if (2'(i) < push_n) begin
				mem[wr_ptr_q + FIFO_AW'(i)] <= push_data[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (FIFO_AW+1)'(push_n) - (FIFO_AW+1)'(pop);
		end
	end

endmodule

@@ design/json_string_unescaper.sv @@
// Top level of the JSON string unescaper: parse state, limit register,
// byte decoder and result queue. Depends on jsu_pkg, jsu_decode, jsu_out_fifo.
//
// Usage:
//  - Input channel (in_valid/in_stall, in_byte, start_req): one raw byte of a
//    quoted JSON string per request; start_req marks the opening quote.
//  - Output channel (out_valid/out_stall, out_byte, status, last): one result
//    per request; status 0 byte, 1 closed, 2 malformed, 3 too long. last
//    flags the final result caused by an input byte.
//  - cfg_wr_en/cfg_wr_data write max_decoded_bytes; write only while idle.
//  - A result is registered in the result queue before it is visible.
//  - Throughput: one input byte per cycle while each byte gives at most one
//    result and out_stall is low. A \uXXXX escape that encodes to three
//    UTF-8 bytes holds off input while the four-entry result queue drains;
//    the queue depth sets how long.
//  - in_stall rises when the queue cannot take a full three-result burst,
//    so a stalled receiver backs up into the input after at most four
//    queued results.
//  - Reset: parse state idle, count and code point zero, limit 32768,
//    queue empty.
module json_string_unescaper (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        start_req,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic [1:0]  status,
	output logic        last,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data
);
	import jsu_pkg::*;

	// parse state, advanced once per accepted request
	mode_t       mode_q;
	logic [15:0] cp_q;
	logic [1:0]  hex_cnt_q;
	logic [15:0] count_q;
	logic [15:0] limit_q;

	decode_t     dec;
	logic        room;
	logic        accept;
	logic [1:0]  push_n;
	result_t     head;

	assign in_stall = !room;
	assign accept   = in_valid && room;
	assign push_n   = accept ? dec.nres : 2'd0;

	jsu_decode u_decode (
		.in_byte   (in_byte),
		.start_req (start_req),
		.mode      (mode_q),
		.cp        (cp_q),
		.hex_cnt   (hex_cnt_q),
		.count     (count_q),
		.limit     (limit_q),
		.dec       (dec)
	);

	// results land in the queue in the same cycle the request is taken
	jsu_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.push_data (dec.res),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign out_byte = head.data;
	assign status   = head.status;
	assign last     = head.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			cp_q      <= '0;
			hex_cnt_q <= '0;
			count_q   <= '0;
		end else if (accept) begin
			mode_q    <= dec.mode;
			cp_q      <= dec.cp;
			hex_cnt_q <= dec.hex_cnt;
			count_q   <= dec.count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

endmodule
